>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define CHK_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("scheduler port check failed");

// Next-cycle implication, masked while reset is low.
`define CHK_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("scheduler port check failed");

// Next-cycle implication that also watches the reset cycles.
`define CHK_RESET(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) (ant) |=> (cons)) \
    else $error("scheduler reset check failed");

`endif

>>> sv/cts_pkg.sv
package cts_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SEL_W     = 3;
  localparam int EXT_W     = (SLOT_W > SEL_W) ? SLOT_W : SEL_W;
  localparam int MAX_RES   = 8;
  localparam int CNT_W     = $clog2(MAX_RES + 1);
  localparam int CQ_DEPTH  = 2;
  localparam int RQ_DEPTH  = 2;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_DISP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_TASK = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ADD,
    OP_DEL,
    OP_DEL_BAD,
    OP_DISP
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_PROC,
    B_ADD,
    B_RESP
  } bstate_t;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  slot_sel;
    logic [15:0] start_delay;
    logic [15:0] repeat_period;
    logic [7:0]  task_tag;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  slot_out;
    logic [7:0]  tag_out;
    logic        ran;
    logic        last;
  } out_item_t;

  // Classified command handed from the front end to the sequencer.
  typedef struct packed {
    op_t         op;
    slot_idx_t   idx;
    logic [2:0]  sel;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  tag;
  } job_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  runs;
  } slot_ent_t;

  function automatic logic [2:0] slot_out_f(slot_idx_t i);
    logic [EXT_W-1:0] e;
    e = EXT_W'(i);
    return e[2:0];
  endfunction

  function automatic slot_idx_t sel_idx_f(logic [2:0] s);
    logic [EXT_W-1:0] e;
    e = EXT_W'(s);
    return e[SLOT_W-1:0];
  endfunction

  function automatic logic sel_ok_f(logic [2:0] s);
    return (32'(s) < NUM_SLOTS);
  endfunction

endpackage

>>> sv/cts_front.sv
module cts_front import cts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  output logic     job_valid,
  output job_t     job,
  input  logic     job_take
);

  localparam int PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CW = $clog2(CQ_DEPTH + 1);

  job_t          q_r [CQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  job_t          job_in;
  logic          do_push, do_pop;

  // Decode the command, range-check the slot and pre-add the start delay.
  always_comb begin
    job_in.idx    = sel_idx_f(in_data.slot_sel);
    job_in.sel    = in_data.slot_sel;
    job_in.delay  = in_data.start_delay + 16'd1;
    job_in.period = in_data.repeat_period;
    job_in.tag    = in_data.task_tag;
    unique case (in_data.cmd)
      CMD_TICK: job_in.op = OP_TICK;
      CMD_ADD:  job_in.op = OP_ADD;
      CMD_DEL:  job_in.op = sel_ok_f(in_data.slot_sel) ? OP_DEL : OP_DEL_BAD;
      CMD_DISP: job_in.op = OP_DISP;
      default:  job_in.op = OP_TICK;
    endcase
  end

  assign full      = (cnt_r == CW'(CQ_DEPTH));
  assign job_valid = (cnt_r != '0);
  assign job       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = job_take && job_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

>>> sv/cts_resq.sv
module cts_resq import cts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_push,
  input  out_item_t res,
  output logic      res_full,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  localparam int PW = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
  localparam int CW = $clog2(RQ_DEPTH + 1);

  out_item_t     q_r [RQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign res_full = (cnt_r == CW'(RQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign out_data = q_r[rd_ptr_r];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(RQ_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(RQ_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

>>> sv/cts_back.sv
module cts_back import cts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_take,
  output logic      res_push,
  output out_item_t res,
  input  logic      res_full
);

  bstate_t              state_r, state_nxt;
  job_t                 cur_r, cur_nxt;
  slot_idx_t            idx_r, idx_nxt;
  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  out_item_t            pend_r, pend_nxt;
  out_item_t            res_r, res_nxt;

  slot_ent_t            slot_mem_r [NUM_SLOTS];
  slot_ent_t            rd_q_r;
  slot_ent_t            wdata;
  logic                 we;

  logic                 idx_last;
  logic                 found;
  logic                 done;
  logic [15:0]          dec;
  out_item_t            none_res;

  assign idx_last = (idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign found    = used_r[idx_r] && (rd_q_r.runs != 8'd0);
  assign dec      = rd_q_r.delay - 16'd1;

  always_comb begin
    none_res.status   = ST_OK;
    none_res.slot_out = 3'd0;
    none_res.tag_out  = 8'd0;
    none_res.ran      = 1'b0;
    none_res.last     = 1'b1;
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    used_nxt     = used_r;
    cnt_nxt      = cnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    res_nxt      = res_r;
    job_take     = 1'b0;
    res_push     = 1'b0;
    res          = res_r;
    we           = 1'b0;
    wdata        = rd_q_r;
    done         = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          job_take     = 1'b1;
          cur_nxt      = job;
          idx_nxt      = '0;
          cnt_nxt      = '0;
          pend_vld_nxt = 1'b0;
          res_nxt      = none_res;
          unique case (job.op) inside
            OP_TICK, OP_DISP: state_nxt = B_READ;
            OP_ADD:           state_nxt = B_ADD;
            OP_DEL: begin
              res_nxt.status    = used_r[job.idx] ? ST_OK : ST_NO_TASK;
              res_nxt.slot_out  = job.sel;
              used_nxt[job.idx] = 1'b0;
              state_nxt         = B_RESP;
            end
            OP_DEL_BAD: begin
              res_nxt.status   = ST_NO_TASK;
              res_nxt.slot_out = job.sel;
              state_nxt        = B_RESP;
            end
            default: state_nxt = B_IDLE;
          endcase
        end
      end

      B_READ: state_nxt = B_PROC;

      B_PROC: begin
        if (cur_r.op == OP_TICK) begin
          if (used_r[idx_r]) begin
            we          = 1'b1;
            wdata.delay = dec;
            if (dec == 16'd0) begin
              wdata.runs = rd_q_r.runs + 8'd1;
              if (rd_q_r.period != 16'd0) begin
                wdata.delay = rd_q_r.period;
              end
            end
          end
          if (idx_last) begin
            res_nxt   = none_res;
            state_nxt = B_RESP;
          end else begin
            idx_nxt   = idx_r + SLOT_W'(1);
            state_nxt = B_READ;
          end
        end else if (!(found && pend_vld_r && res_full)) begin
          // Release the held result once a newer one shows it was not the final one.
          if (found) begin
            res_push          = pend_vld_r;
            res               = pend_r;
            pend_nxt.status   = ST_OK;
            pend_nxt.slot_out = slot_out_f(idx_r);
            pend_nxt.tag_out  = rd_q_r.tag;
            pend_nxt.ran      = 1'b1;
            pend_nxt.last     = 1'b0;
            pend_vld_nxt      = 1'b1;
            cnt_nxt           = cnt_r + CNT_W'(1);
            we                = 1'b1;
            wdata.runs        = rd_q_r.runs - 8'd1;
            if (rd_q_r.period == 16'd0) begin
              used_nxt[idx_r] = 1'b0;
            end
          end
          done = idx_last || (found && (cnt_r == CNT_W'(MAX_RES - 1)));
          if (done) begin
            if (pend_vld_nxt) begin
              res_nxt      = pend_nxt;
              res_nxt.last = 1'b1;
            end else begin
              res_nxt = none_res;
            end
            state_nxt = B_RESP;
          end else begin
            idx_nxt   = idx_r + SLOT_W'(1);
            state_nxt = B_READ;
          end
        end
      end

      B_ADD: begin
        if (!used_r[idx_r]) begin
          used_nxt[idx_r]  = 1'b1;
          we               = 1'b1;
          wdata.tag        = cur_r.tag;
          wdata.delay      = cur_r.delay;
          wdata.period     = cur_r.period;
          wdata.runs       = 8'd0;
          res_nxt          = none_res;
          res_nxt.slot_out = slot_out_f(idx_r);
          state_nxt        = B_RESP;
        end else if (idx_last) begin
          res_nxt        = none_res;
          res_nxt.status = ST_FULL;
          state_nxt      = B_RESP;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end

      B_RESP: begin
        res = res_r;
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = B_IDLE;
        end
      end

      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      used_r     <= '0;
      pend_vld_r <= 1'b0;
      cnt_r      <= '0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      pend_vld_r <= pend_vld_nxt;
      cnt_r      <= cnt_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    pend_r <= pend_nxt;
    res_r  <= res_nxt;
  end

  // Slot memory: one port, shared address, registered read.
  always_ff @(posedge clk) begin
    rd_q_r <= slot_mem_r[idx_r];
    if (we) begin
      slot_mem_r[idx_r] <= wdata;
    end
  end

endmodule

>>> sv/cooperative_task_scheduler.sv
// Delete answers straight from the used flags; add scans for the first free slot;
//   tick and dispatch walk the slot table (dispatch longer if the result queue backs up).
// The sequencer finishes one command before it takes the next; each tick or dispatch
//   slot visit is a read then an update of the one-port slot memory.
// Reset (rst_n low, synchronous): all slots free, both queues empty, sequencer idle.
module cooperative_task_scheduler import cts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  // Front end: take one beat per push, decode it, and park it in a short job queue.
  job_t      job;
  logic      job_valid;
  logic      job_take;

  // Back end results travel through a small queue so the sequencer can run ahead.
  out_item_t res;
  logic      res_push;
  logic      res_full;

  cts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  // Sequencer: walk the slot table one slot at a time for tick, dispatch and add;
  // hold each dispatch beat until the next one shows whether it is the final one.
  cts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  cts_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

>>> sv/cts_checker.sv
`include "assert_macros.svh"

module cts_checker import cts_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data
);

  `CHK_RESET(a_reset_clears, !rst_n, empty && !full)
  `CHK_NEXT(a_hold_stalled, !empty && !pop, !empty && $stable(out_data))
  `CHK_IMPL(a_only_dispatch_continues, !empty && !out_data.last, out_data.ran)
  `CHK_IMPL(a_idle_tag_zero, !empty && !out_data.ran, out_data.tag_out == 8'd0)

endmodule

bind cooperative_task_scheduler cts_checker u_cts_checker (.*);

>>> dv/cooperative_task_scheduler_tb.sv
`timescale 1ns / 100ps
module cooperative_task_scheduler_tb;
  import cts_pkg::*;

  // Cycles with no beat on either side before the run is declared hung.
  // The slowest beat-to-beat gap is a sender gap, a full dispatch pass and
  // eight results that each wait out a receiver stall.
  localparam int IDLE_LIMIT   = 4000;
  // Cycles to keep watching the result side once nothing is expected.
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 100;
  // A run of ticks that piles up several runs on a period-1 slot.
  localparam int STORM_TICKS  = 30;
  localparam int PRINT_CAP    = 40;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;

  // Shadow copy of the slot table plus the beats the block still owes.
  class slot_table_model;
    logic        used   [NUM_SLOTS];
    logic [7:0]  tag    [NUM_SLOTS];
    logic [15:0] delay  [NUM_SLOTS];
    logic [15:0] period [NUM_SLOTS];
    logic [7:0]  runs   [NUM_SLOTS];
    out_item_t   want_beats[$];
    int          errors;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) clear_slot(i);
      errors = 0;
    endfunction

    function void clear_slot(int i);
      used[i]   = 1'b0;
      tag[i]    = '0;
      delay[i]  = '0;
      period[i] = '0;
      runs[i]   = '0;
    endfunction

    function int used_count();
      int n;
      n = 0;
      for (int i = 0; i < NUM_SLOTS; i++) if (used[i]) n++;
      return n;
    endfunction

    function out_item_t beat(status_t st, int slot, logic [7:0] t, logic r, logic l);
      out_item_t b;
      b.status   = st;
      b.slot_out = 3'(slot);
      b.tag_out  = t;
      b.ran      = r;
      b.last     = l;
      return b;
    endfunction

    // Advance the shadow table by one accepted command and queue its beats.
    function void note_command(in_item_t it);
      int        free_slot;
      int        n;
      status_t   st;
      out_item_t b;
      case (it.cmd)
        CMD_TICK: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!used[i]) continue;
            delay[i] = delay[i] - 16'd1;
            if (delay[i] == 16'd0) begin
              runs[i] = runs[i] + 8'd1;
              if (period[i] != 16'd0) delay[i] = period[i];
            end
          end
          want_beats.push_back(beat(ST_OK, 0, 8'd0, 1'b0, 1'b1));
        end
        CMD_ADD: begin
          free_slot = -1;
          for (int i = NUM_SLOTS - 1; i >= 0; i--) if (!used[i]) free_slot = i;
          if (free_slot < 0) begin
            want_beats.push_back(beat(ST_FULL, 0, 8'd0, 1'b0, 1'b1));
          end else begin
            used[free_slot]   = 1'b1;
            tag[free_slot]    = it.task_tag;
            delay[free_slot]  = it.start_delay + 16'd1;
            period[free_slot] = it.repeat_period;
            runs[free_slot]   = 8'd0;
            want_beats.push_back(beat(ST_OK, free_slot, 8'd0, 1'b0, 1'b1));
          end
        end
        CMD_DEL: begin
          st = ST_NO_TASK;
          if (int'(it.slot_sel) < NUM_SLOTS) begin
            if (used[it.slot_sel]) st = ST_OK;
            clear_slot(int'(it.slot_sel));
          end
          want_beats.push_back(beat(st, int'(it.slot_sel), 8'd0, 1'b0, 1'b1));
        end
        default: begin
          n = 0;
          for (int i = 0; i < NUM_SLOTS && n < MAX_RES; i++) begin
            if (runs[i] == 8'd0) continue;
            want_beats.push_back(beat(ST_OK, i, tag[i], 1'b1, 1'b0));
            n++;
            runs[i] = runs[i] - 8'd1;
            if (period[i] == 16'd0) clear_slot(i);
          end
          if (n == 0) begin
            want_beats.push_back(beat(ST_OK, 0, 8'd0, 1'b0, 1'b1));
          end else begin
            b = want_beats.pop_back();
            b.last = 1'b1;
            want_beats.push_back(b);
          end
        end
      endcase
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("mismatch: %s", msg);
      errors++;
    endtask

    // Compare one accepted result beat against the oldest expectation.
    task check_beat(out_item_t got);
      out_item_t w;
      if (want_beats.size() == 0) begin
        report($sformatf("unexpected beat status=%0d slot=%0d tag=%h ran=%b last=%b",
                         got.status, got.slot_out, got.tag_out, got.ran, got.last));
        return;
      end
      w = want_beats.pop_front();
      if (got.status !== w.status)
        report($sformatf("status got %0d want %0d", got.status, w.status));
      if (got.slot_out !== w.slot_out)
        report($sformatf("slot_out got %0d want %0d", got.slot_out, w.slot_out));
      if (got.tag_out !== w.tag_out)
        report($sformatf("tag_out got %h want %h", got.tag_out, w.tag_out));
      if (got.ran !== w.ran)
        report($sformatf("ran got %b want %b (slot %0d)", got.ran, w.ran, w.slot_out));
      if (got.last !== w.last)
        report($sformatf("last got %b want %b (slot %0d)", got.last, w.last, w.slot_out));
    endtask
  endclass

  slot_table_model sched_model;

  int burst_left  = 0;
  int rx_run      = 0;
  int rx_hold     = 0;
  int idle_cycles = 0;

  cooperative_task_scheduler uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic in_item_t mk_item(cmd_t c, logic [2:0] sel, logic [15:0] d,
                                       logic [15:0] p, logic [7:0] t);
    in_item_t it;
    it.cmd           = c;
    it.slot_sel      = sel;
    it.start_delay   = d;
    it.repeat_period = p;
    it.task_tag      = t;
    return it;
  endfunction

  // Draw one random command. Keep delays and periods mostly short so that
  // ticks actually make slots ready; fill unused fields with noise.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       roll;
    pick             = $urandom_range(0, 99);
    it.slot_sel      = 3'($urandom);
    it.task_tag      = 8'($urandom);
    it.start_delay   = 16'($urandom);
    it.repeat_period = 16'($urandom);
    if (pick < 33)      it.cmd = CMD_TICK;
    else if (pick < 63) it.cmd = CMD_ADD;
    else if (pick < 75) it.cmd = CMD_DEL;
    else                it.cmd = CMD_DISP;
    if (it.cmd == CMD_ADD) begin
      roll = $urandom_range(0, 9);
      if (roll < 7)       it.start_delay = 16'($urandom_range(0, 5));
      else if (roll == 7) it.start_delay = 16'hFFFF;
      roll = $urandom_range(0, 9);
      if (roll < 4)       it.repeat_period = 16'd0;
      else if (roll < 8)  it.repeat_period = 16'($urandom_range(1, 4));
    end
    return it;
  endfunction

  // Insert a random gap between bursts; drop push only when a gap is taken.
  task automatic pause_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 12);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Present one beat and hold it until the block takes it.
  task automatic send_item(in_item_t it);
    pause_sender();
    in_data <= it;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sched_model.note_command(it);
  endtask

  // Result side: check every accepted beat, then pick pop for the next edge
  // from alternating runs of pops and stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sched_model.check_beat(out_data);
      if (rx_run == 0 && rx_hold == 0) begin
        rx_run  = $urandom_range(1, 16);
        rx_hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      end
      if (rx_run > 0) begin
        rx_run--;
        pop <= 1'b1;
      end else begin
        rx_hold--;
        pop <= 1'b0;
      end
    end
  end

  // Watchdog: any beat on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sched_model = new();
    rst_n   = 1'b0;
    push    = 1'b0;
    pop     = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: nothing ready, delete of an empty slot, tick with no tasks.
    send_item(mk_item(CMD_DISP, 3'd0, 16'h0000, 16'h0000, 8'h00));
    send_item(mk_item(CMD_DEL,  3'd0, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_item(mk_item(CMD_TICK, 3'd7, 16'h0000, 16'h0000, 8'h00));

    // Fill all slots: a one-shot, a task whose delay+1 wraps to zero, and
    // six period-1 tasks; then one more add hits a full table.
    send_item(mk_item(CMD_ADD, 3'd7, 16'h0000, 16'h0000, 8'hFF));
    send_item(mk_item(CMD_ADD, 3'd0, 16'hFFFF, 16'hFFFF, 8'h00));
    for (int i = 2; i < NUM_SLOTS; i++)
      send_item(mk_item(CMD_ADD, 3'(i), 16'h0000, 16'h0001, 8'(8'h10 * i + i)));
    send_item(mk_item(CMD_ADD, 3'd5, 16'h1234, 16'h0002, 8'hAA));

    // Two ticks: the wrapped slot goes from zero to the top and stays not due.
    send_item(mk_item(CMD_TICK, 3'd0, 16'h0000, 16'h0000, 8'h00));
    send_item(mk_item(CMD_TICK, 3'd0, 16'h0000, 16'h0000, 8'h00));

    // Replace the long-delay task, tick once more, then dispatch with every
    // slot ready so the full eight beats come out in index order.
    send_item(mk_item(CMD_DEL, 3'd1, 16'h0000, 16'h0000, 8'h00));
    send_item(mk_item(CMD_ADD, 3'd2, 16'h0000, 16'h0001, 8'h3C));
    send_item(mk_item(CMD_TICK, 3'd0, 16'h0000, 16'h0000, 8'h00));
    send_item(mk_item(CMD_DISP, 3'd0, 16'h0000, 16'h0000, 8'h00));
    send_item(mk_item(CMD_DISP, 3'd0, 16'h0000, 16'h0000, 8'h00));

    // Deletes across the index range, one of them twice.
    send_item(mk_item(CMD_DEL, 3'd7, 16'h0000, 16'h0000, 8'h00));
    send_item(mk_item(CMD_DEL, 3'd7, 16'h0000, 16'h0000, 8'h00));
    send_item(mk_item(CMD_DEL, 3'd5, 16'h0000, 16'h0000, 8'h00));
    send_item(mk_item(CMD_DISP, 3'd0, 16'h0000, 16'h0000, 8'h00));

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) begin
        // Tick storm: free a slot, park a period-1 task in it and tick long
        // enough for its run count to climb well past one before the dispatch.
        send_item(mk_item(CMD_DEL, 3'd0, 16'h0000, 16'h0000, 8'h00));
        send_item(mk_item(CMD_ADD, 3'd0, 16'h0000, 16'h0001, 8'hC3));
        for (int t = 0; t < STORM_TICKS; t++)
          send_item(mk_item(CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
                            8'($urandom)));
        send_item(mk_item(CMD_DISP, 3'd0, 16'h0000, 16'h0000, 8'h00));
      end
      send_item(random_item());
    end
    push <= 1'b0;

    // Drain: wait for every owed beat, then watch for strays.
    while (sched_model.want_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sched_model.want_beats.size() != 0)
      sched_model.report($sformatf("%0d beats never arrived", sched_model.want_beats.size()));

    if (sched_model.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> cooperative_task_scheduler.f
+incdir+sv
sv/cts_pkg.sv
sv/cts_front.sv
sv/cts_resq.sv
sv/cts_back.sv
sv/cooperative_task_scheduler.sv
sv/cts_checker.sv
dv/cooperative_task_scheduler_tb.sv
